// File: design/sphere_aabb_penetration_defines.svh
// Assertion helpers for the checker file.
`ifndef SPHERE_AABB_PENETRATION_DEFINES_SVH
`define SPHERE_AABB_PENETRATION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SAAP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SAAP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/saap_pkg.sv
`default_nettype none
package saap_pkg;

	// Push axis selector for the inside case
	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

endpackage
`default_nettype wire

// File: design/saap_isqrt.sv
`default_nettype none
// Pipelined integer square root, one root bit per stage.
module saap_isqrt import saap_pkg::*; #(
	parameter int COORD_BITS = 32,
	parameter int SIDE_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [2*COORD_BITS-3:0]   in_rad,
	input  logic [SIDE_W-1:0]         in_side,
	output logic                      out_vld,
	output logic [COORD_BITS-2:0]     out_root,
	output logic [SIDE_W-1:0]         out_side
);

	localparam int W  = COORD_BITS;
	localparam int NB = 2 * W - 2;
	localparam int RB = W - 1;
	localparam int RW = W + 2;

	logic [NB-1:0]     rad_s  [RB];
	logic [RW-1:0]     rem_s  [RB];
	logic [RB-1:0]     root_s [RB];
	logic [SIDE_W-1:0] side_s [RB];
	logic [RB-1:0]     vld_s;

	for (genvar k = 0; k < RB; k++) begin : g_stage
		logic [NB-1:0]     rad_p;
		logic [RW-1:0]     rem_p;
		logic [RB-1:0]     root_p;
		logic [SIDE_W-1:0] side_p;
		logic              vld_p;
		logic [RW-1:0]     remx;
		logic [RW-1:0]     trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rad_p  = in_rad;
			assign rem_p  = '0;
			assign root_p = '0;
			assign side_p = in_side;
			assign vld_p  = in_vld;
		end else begin : g_next
			assign rad_p  = rad_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		// bring down two radicand bits, try root*4+1
		assign remx  = {rem_p[RW-3:0], rad_p[NB-1:NB-2]};
		assign trial = {1'b0, root_p, 2'b01};
		assign ge    = (remx >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_p[NB-3:0], 2'b00};
				rem_s[k]  <= ge ? (remx - trial) : remx;
				root_s[k] <= {root_p[RB-2:0], ge};
				side_s[k] <= side_p;
			end
		end
	end

	assign out_vld  = vld_s[RB-1];
	assign out_root = root_s[RB-1];
	assign out_side = side_s[RB-1];

endmodule
`default_nettype wire

// File: design/saap_div.sv
`default_nettype none
// Three-lane pipelined restoring divider sharing one divisor.
// Gives the low COORD_BITS-1 quotient bits and a flag when the quotient is larger.
module saap_div import saap_pkg::*; #(
	parameter int COORD_BITS = 32,
	parameter int SIDE_W = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_vld,
	input  logic [2:0][2*COORD_BITS-3:0]    in_num,
	input  logic [COORD_BITS-2:0]           in_den,
	input  logic [SIDE_W-1:0]               in_side,
	output logic                            out_vld,
	output logic [2:0][COORD_BITS-2:0]      out_q,
	output logic [2:0]                      out_big,
	output logic [SIDE_W-1:0]               out_side
);

	localparam int W  = COORD_BITS;
	localparam int NB = 2 * W - 2;
	localparam int QB = W - 1;

	logic [QB-1:0]     rem_s  [QB+1][3];
	logic [QB-1:0]     lo_s   [QB+1][3];
	logic [QB-1:0]     q_s    [QB+1][3];
	logic              big_s  [QB+1][3];
	logic [QB-1:0]     den_s  [QB+1];
	logic [SIDE_W-1:0] side_s [QB+1];
	logic [QB:0]       vld_s;

	// stage 0: overflow check and start remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= in_num[l][NB-1:QB];
				lo_s[0][l]  <= in_num[l][QB-1:0];
				big_s[0][l] <= (in_num[l][NB-1:QB] >= in_den);
				q_s[0][l]   <= '0;
			end
			den_s[0]  <= in_den;
			side_s[0] <= in_side;
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= QB; k++) begin : g_stage
		logic [QB:0] remx [3];
		logic        ge   [3];

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				remx[l] = {rem_s[k-1][l], lo_s[k-1][l][QB-1]};
				ge[l]   = (remx[l] >= {1'b0, den_s[k-1]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					rem_s[k][l] <= ge[l] ? QB'(remx[l] - {1'b0, den_s[k-1]}) : remx[l][QB-1:0];
					lo_s[k][l]  <= {lo_s[k-1][l][QB-2:0], 1'b0};
					q_s[k][l]   <= {q_s[k-1][l][QB-2:0], ge[l]};
					big_s[k][l] <= big_s[k-1][l];
				end
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			out_q[l]   = q_s[QB][l];
			out_big[l] = big_s[QB][l];
		end
	end

	assign out_vld  = vld_s[QB];
	assign out_side = side_s[QB];

endmodule
`default_nettype wire

// File: design/sphere_aabb_penetration.sv
// Throughput: one beat per cycle while the output skid entry is empty.
// The square root and the divider are one bit per stage.
// A two-entry output buffer lets input beats in while one result waits.
// Reset (arst_n low) clears all valid bits and the output buffer; data is not cleared.
`default_nettype none
module sphere_aabb_penetration import saap_pkg::*; #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// sphere_x, sphere_y, sphere_z, sphere_radius, box_min_x, box_min_y, box_min_z,
	// box_max_x, box_max_y, box_max_z, zero fill
	input  logic [((10*COORD_BITS-1+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// hit, push_x, push_y, push_z, zero fill
	output logic [((3*COORD_BITS+1+7)/8)*8-1:0] m_axis_tdata
);

	localparam int W     = COORD_BITS;
	localparam int NB    = 2 * W - 2;
	localparam int OUT_W = ((3 * W + 1 + 7) / 8) * 8;
	localparam int EPS_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
	localparam logic [2*W-1:0] EPS_SQ = (2*W)'(EPS_RAW * EPS_RAW);
	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic                 hit;
		logic                 outd;
		logic [2:0][W-1:0]    ipush;
		logic [2:0][W-2:0]    ad;
		logic [2:0]           neg;
		logic [W-2:0]         r;
	} side_t;

	typedef struct packed {
		logic                 hit;
		logic                 outd;
		logic [2:0][W-1:0]    ipush;
		logic [2:0]           neg;
	} dside_t;

	logic en;

	// input fields
	logic signed [W-1:0] c_in  [3];
	logic signed [W-1:0] mn_in [3];
	logic signed [W-1:0] mx_in [3];
	logic        [W-2:0] r_in;

	for (genvar i = 0; i < 3; i++) begin : g_fields
		assign c_in[i]  = s_axis_tdata[i*W +: W];
		assign mn_in[i] = s_axis_tdata[4*W-1 + i*W +: W];
		assign mx_in[i] = s_axis_tdata[7*W-1 + i*W +: W];
	end
	assign r_in = s_axis_tdata[3*W +: W-1];

	// s1: clamp, doubled offset from box center, box width
	logic signed [W-1:0] cl_in [3];
	logic signed [W+1:0] o_in  [3];
	logic signed [W:0]   w_in  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cl_in[i] = (c_in[i] < mx_in[i]) ? c_in[i] : mx_in[i];
			if (cl_in[i] < mn_in[i]) begin
				cl_in[i] = mn_in[i];
			end
			o_in[i] = ((W+2)'(c_in[i]) <<< 1) - (W+2)'(mn_in[i]) - (W+2)'(mx_in[i]);
			w_in[i] = (W+1)'(mx_in[i]) - (W+1)'(mn_in[i]);
		end
	end

	logic                vld_s1;
	logic signed [W-1:0] c_s1  [3];
	logic signed [W-1:0] cl_s1 [3];
	logic signed [W+1:0] o_s1  [3];
	logic signed [W:0]   w_s1  [3];
	logic        [W-2:0] r_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1  <= c_in;
			cl_s1 <= cl_in;
			o_s1  <= o_in;
			w_s1  <= w_in;
			r_s1  <= r_in;
		end
	end

	// s2: offset to closest point, its magnitude, face clearance
	logic signed [W:0]   d_c   [3];
	logic        [W:0]   ad_c  [3];
	logic        [W+1:0] ao_c  [3];
	logic signed [W+2:0] c2_c  [3];
	logic                near_c;

	always_comb begin
		near_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			d_c[i]  = (W+1)'(c_s1[i]) - (W+1)'(cl_s1[i]);
			ad_c[i] = d_c[i][W] ? (W+1)'(-d_c[i]) : d_c[i];
			if (ad_c[i] >= (W+1)'(r_s1)) begin
				near_c = 1'b0;
			end
			ao_c[i] = o_s1[i][W+1] ? (W+2)'(-o_s1[i]) : o_s1[i];
			c2_c[i] = (W+3)'(w_s1[i]) - $signed({1'b0, ao_c[i]});
		end
	end

	logic                vld_s2;
	logic        [W-2:0] ad_s2  [3];
	logic        [2:0]   neg_s2;
	logic                near_s2;
	logic signed [W+2:0] c2_s2  [3];
	logic        [2:0]   pos_s2;
	logic        [W-2:0] r_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ad_s2[i]  <= ad_c[i][W-2:0];
				neg_s2[i] <= d_c[i][W];
				c2_s2[i]  <= c2_c[i];
				pos_s2[i] <= ~o_s1[i][W+1];
			end
			near_s2 <= near_c;
			r_s2    <= r_s1;
		end
	end

	// s3: squares, radius squared, least-clearance axis
	axis_t               ax_c;
	logic signed [W+2:0] csel_c;
	logic                psel_c;

	always_comb begin
		if (c2_s2[0] < c2_s2[1] && c2_s2[0] < c2_s2[2]) begin
			ax_c = AXIS_X;
		end else if (c2_s2[1] < c2_s2[2]) begin
			ax_c = AXIS_Y;
		end else begin
			ax_c = AXIS_Z;
		end
		unique case (ax_c)
			AXIS_X: begin
				csel_c = c2_s2[0];
				psel_c = pos_s2[0];
			end
			AXIS_Y: begin
				csel_c = c2_s2[1];
				psel_c = pos_s2[1];
			end
			default: begin
				csel_c = c2_s2[2];
				psel_c = pos_s2[2];
			end
		endcase
	end

	logic                vld_s3;
	logic        [NB-1:0] sqp_s3 [3];
	logic        [NB-1:0] rr_s3;
	axis_t               ax_s3;
	logic signed [W+2:0] csel_s3;
	logic                psel_s3;
	logic        [W-2:0] ad_s3  [3];
	logic        [2:0]   neg_s3;
	logic                near_s3;
	logic        [W-2:0] r_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqp_s3[i] <= NB'(ad_s2[i]) * NB'(ad_s2[i]);
			end
			rr_s3   <= NB'(r_s2) * NB'(r_s2);
			ax_s3   <= ax_c;
			csel_s3 <= csel_c;
			psel_s3 <= psel_c;
			ad_s3   <= ad_s2;
			neg_s3  <= neg_s2;
			near_s3 <= near_s2;
			r_s3    <= r_s2;
		end
	end

	// s4: squared distance, inside magnitude floor((c2 + 2r) / 2)
	logic                vld_s4;
	logic        [2*W-1:0] sq_s4;
	logic signed [W+3:0] imag_s4;
	axis_t               ax_s4;
	logic                psel_s4;
	logic        [W-2:0] ad_s4  [3];
	logic        [2:0]   neg_s4;
	logic                near_s4;
	logic        [W-2:0] r_s4;
	logic        [NB-1:0] rr_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4   <= (2*W)'(sqp_s3[0]) + (2*W)'(sqp_s3[1]) + (2*W)'(sqp_s3[2]);
			imag_s4 <= ((W+4)'(csel_s3) + $signed({4'b0, r_s3, 1'b0})) >>> 1;
			ax_s4   <= ax_s3;
			psel_s4 <= psel_s3;
			ad_s4   <= ad_s3;
			neg_s4  <= neg_s3;
			near_s4 <= near_s3;
			r_s4    <= r_s3;
			rr_s4   <= rr_s3;
		end
	end

	// s5: hit and mode decision, signed and saturated inside push
	logic signed [W+3:0] iv_c;
	logic        [W-1:0] isat_c;
	side_t               sd_c;

	always_comb begin
		iv_c = psel_s4 ? imag_s4 : -imag_s4;
		if ((&iv_c[W+3:W-1]) || !(|iv_c[W+3:W-1])) begin
			isat_c = iv_c[W-1:0];
		end else begin
			isat_c = iv_c[W+3] ? VMIN : VMAX;
		end
		sd_c.hit   = near_s4 && (sq_s4 < (2*W)'(rr_s4));
		sd_c.outd  = (sq_s4 > EPS_SQ);
		sd_c.ipush = '0;
		unique case (ax_s4)
			AXIS_X:  sd_c.ipush[0] = isat_c;
			AXIS_Y:  sd_c.ipush[1] = isat_c;
			default: sd_c.ipush[2] = isat_c;
		endcase
		for (int i = 0; i < 3; i++) begin
			sd_c.ad[i] = ad_s4[i];
		end
		sd_c.neg = neg_s4;
		sd_c.r   = r_s4;
	end

	logic          vld_s5;
	logic [NB-1:0] sq_s5;
	side_t         sd_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5 <= sq_s4[NB-1:0];
			sd_s5 <= sd_c;
		end
	end

	// distance = floor(sqrt(sq))
	logic         sq_vld;
	logic [W-2:0] root;
	side_t        sq_side;

	saap_isqrt #(
		.COORD_BITS(COORD_BITS),
		.SIDE_W($bits(side_t))
	) u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s5),
		.in_rad(sq_s5),
		.in_side(sd_s5),
		.out_vld(sq_vld),
		.out_root(root),
		.out_side(sq_side)
	);

	// s6: penetration depth
	logic         vld_s6;
	logic [W-2:0] pen_s6;
	logic [W-2:0] dist_s6;
	side_t        side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			pen_s6  <= sq_side.r - root;
			dist_s6 <= root;
			side_s6 <= sq_side;
		end
	end

	// s7: |d_i| * depth per axis
	logic                vld_s7;
	logic [2:0][NB-1:0]  num_s7;
	logic [W-2:0]        dist_s7;
	dside_t              dside_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s7[i] <= NB'(side_s6.ad[i]) * NB'(pen_s6);
			end
			dist_s7        <= dist_s6;
			dside_s7.hit   <= side_s6.hit;
			dside_s7.outd  <= side_s6.outd;
			dside_s7.ipush <= side_s6.ipush;
			dside_s7.neg   <= side_s6.neg;
		end
	end

	// divide by distance
	logic              dv_vld;
	logic [2:0][W-2:0] dv_q;
	logic [2:0]        dv_big;
	dside_t            dv_side;

	saap_div #(
		.COORD_BITS(COORD_BITS),
		.SIDE_W($bits(dside_t))
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s7),
		.in_num(num_s7),
		.in_den(dist_s7),
		.in_side(dside_s7),
		.out_vld(dv_vld),
		.out_q(dv_q),
		.out_big(dv_big),
		.out_side(dv_side)
	);

	// final selection of the push vector
	logic [2:0][W-1:0] push_c;
	logic [OUT_W-1:0]  tail_data;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!dv_side.hit) begin
				push_c[i] = '0;
			end else if (dv_side.outd) begin
				if (dv_big[i]) begin
					push_c[i] = dv_side.neg[i] ? VMIN : VMAX;
				end else begin
					push_c[i] = dv_side.neg[i] ? -{1'b0, dv_q[i]} : {1'b0, dv_q[i]};
				end
			end else begin
				push_c[i] = dv_side.ipush[i];
			end
		end
		tail_data = OUT_W'({push_c[2], push_c[1], push_c[0], dv_side.hit});
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= sq_vld;
			vld_s7 <= vld_s6;
		end
	end

	// output register plus skid entry; pipeline holds only while the skid is full
	logic             out_vld_q;
	logic [OUT_W-1:0] out_data_q;
	logic             skid_vld_q;
	logic [OUT_W-1:0] skid_data_q;

	assign en = ~skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_axis_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q  <= dv_vld;
			end
		end else if (dv_vld && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_axis_tready) begin
			out_data_q <= skid_vld_q ? skid_data_q : tail_data;
		end else if (dv_vld && en) begin
			skid_data_q <= tail_data;
		end
	end

	assign s_axis_tready = en;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// File: design/saap_checker.sv
`default_nettype none
`include "sphere_aabb_penetration_defines.svh"
// Port-level checks for the sphere/box penetration block.
module saap_checker #(
	parameter int COORD_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((3*COORD_BITS+1+7)/8)*8-1:0] m_axis_tdata
);

	// stalled output beat stays put
	`SAAP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

	// a miss carries a zero push vector
	`SAAP_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[3*COORD_BITS:1] == '0, "miss beat with nonzero push")

	// input backpressure only while a result is waiting at the output
	`SAAP_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid, "input stalled with empty output")

endmodule

bind sphere_aabb_penetration saap_checker #(.COORD_BITS(COORD_BITS)) u_saap_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
